// File: design/sorted_table_binary_search_defines.svh
// Assertion macros shared by the sorted table search design.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTH

`define STBS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stbs: assertion failed");

`define STBS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbs: assertion failed");

`define STBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbs: assertion failed");

`else

`define STBS_ASSERT(lbl, cond)
`define STBS_ASSERT_IMPL(lbl, ante, cons)
`define STBS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/stbs_pkg.sv
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_EXACT = 2'd1,
    FUNC_LOWER = 2'd2
  } func_t;

  // Write side of the key memory.
  typedef struct packed {
    logic en;
    idx_t addr;
    key_t data;
  } ram_wr_t;

  // Read side of the key memory.
  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

endpackage

// File: design/stbs_key_ram.sv
module stbs_key_ram (
  input  logic            clk,
  input  stbs_pkg::ram_wr_t wr,
  input  stbs_pkg::ram_rd_t rd,
  output stbs_pkg::key_t  rd_data
);
  import stbs_pkg::*;

  key_t mem [TABLE_DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/sorted_table_binary_search.sv
// Sorted key table with bisection search.
// Input channel (in_valid/in_ready): each beat carries in_func, in_load_index and
// in_key. A load beat writes in_key into the table at in_load_index and gives no
// result; the block stays idle. An exact or lower-bound search beat runs a bisection
// over the first cfg entries and gives one result beat on the output channel
// (out_valid/out_ready) carrying out_found, out_position and out_was_lower_bound.
// A search issues one key memory read per cycle until it ends, then moves the
// answer into the output register. The probe loop runs through the registered
// memory read and the key compare; one search is in flight at a time. The next
// beat is taken the cycle after the answer is moved out, and an empty-table
// search skips the probes. Unused func codes are accepted and dropped.
// The entry count is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while the block is idle, which the block itself does not enforce. Values
// beyond the table depth saturate. Reset clears the count and all control state;
// table contents stay undefined until loaded.
// A stalled receiver holds the result in the output register while the next
// input beat is still taken; a finished search then waits until the output
// register is free.
`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  stbs_pkg::idx_t       in_load_index,
  input  stbs_pkg::key_t       in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output stbs_pkg::cnt_t       out_position,
  output logic                 out_was_lower_bound,
  input  logic                 cfg_wr_en,
  input  stbs_pkg::cnt_t       cfg_wr_data
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  cnt_t           count_r;
  cnt_t           lo_r, lo_nxt;
  cnt_t           hi_r, hi_nxt;
  idx_t           m_r, m_nxt;
  key_t           key_r, key_nxt;
  logic           exact_r, exact_nxt;
  logic           res_found_r, res_found_nxt;
  cnt_t           res_pos_r, res_pos_nxt;
  logic           res_lb_r, res_lb_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  cnt_t           out_pos_r, out_pos_nxt;
  logic           out_lb_r, out_lb_nxt;

  ram_wr_t        ram_wr;
  ram_rd_t        ram_rd;
  key_t           rd_data;

  logic           is_search;
  logic           key_less;
  logic           key_hit;
  cnt_t           lo_step;
  cnt_t           hi_step;
  cnt_t           probe_lo;
  cnt_t           probe_hi;
  logic [CNT_W:0] probe_sum;
  idx_t           probe_m;

  assign in_ready  = (state_r == ST_IDLE);
  assign is_search = (in_func == FUNC_EXACT) || (in_func == FUNC_LOWER);

  // Loads only land while idle, and a search beat issues its first read in its accept
  // cycle with no load in it, so a read never meets a write to the same entry.
  assign ram_wr.en   = in_valid && in_ready && (in_func == FUNC_LOAD);
  assign ram_wr.addr = in_load_index;
  assign ram_wr.data = in_key;

  stbs_key_ram u_key_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  // The read data belongs to probe m_r; work out the narrowed span at once.
  assign key_less = (rd_data < key_r);
  assign key_hit  = exact_r && (rd_data == key_r);
  assign lo_step  = key_less ? (CNT_W'(m_r) + CNT_W'(1)) : lo_r;
  assign hi_step  = key_less ? hi_r : CNT_W'(m_r);

  assign probe_lo  = (state_r == ST_SRCH) ? lo_step : '0;
  assign probe_hi  = (state_r == ST_SRCH) ? hi_step : count_r;
  assign probe_sum = {1'b0, probe_lo} + {1'b0, probe_hi} - (CNT_W+1)'(1);
  assign probe_m   = probe_sum[IDX_W:1];

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    m_nxt         = m_r;
    key_nxt       = key_r;
    exact_nxt     = exact_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    res_lb_nxt    = res_lb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_lb_nxt    = out_lb_r;
    ram_rd.en     = 1'b0;
    ram_rd.addr   = probe_m;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && is_search) begin
          key_nxt       = in_key;
          exact_nxt     = (in_func == FUNC_EXACT);
          lo_nxt        = '0;
          hi_nxt        = count_r;
          res_found_nxt = (in_func == FUNC_LOWER);
          res_pos_nxt   = '0;
          res_lb_nxt    = (in_func == FUNC_LOWER);
          if (count_r != '0) begin
            ram_rd.en = 1'b1;
            m_nxt     = probe_m;
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        if (key_hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = CNT_W'(m_r);
          state_nxt     = ST_DONE;
        end else begin
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          if (lo_step < hi_step) begin
            ram_rd.en = 1'b1;
            m_nxt     = probe_m;
          end else begin
            if (!exact_r) begin
              res_pos_nxt = lo_step;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          out_lb_nxt    = res_lb_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= (cfg_wr_data > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    m_r         <= m_nxt;
    key_r       <= key_nxt;
    exact_r     <= exact_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_lb_r    <= res_lb_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_lb_r    <= out_lb_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_position        = out_pos_r;
  assign out_was_lower_bound = out_lb_r;

  `STBS_ASSERT(a_count_in_range, count_r <= CNT_W'(TABLE_DEPTH))
  `STBS_ASSERT_IMPL(a_span_live, state_r == ST_SRCH, (lo_r < hi_r) && (hi_r <= count_r))
  `STBS_ASSERT_IMPL(a_no_write_in_search, ram_wr.en, state_r == ST_IDLE)
  `STBS_ASSERT_NEXT(a_search_starts, in_valid && in_ready && is_search, state_r != ST_IDLE)
  `STBS_ASSERT_IMPL(a_bound_in_span, out_valid && out_was_lower_bound, out_position <= count_r)

endmodule
